// File: hw/rtl/palindromic_substring_counter_core_assert.svh
// Assertion helpers used by the palindromic substring counter core.
// Both expect signals named clk and rst in the enclosing scope.
`ifndef PALINDROMIC_SUBSTRING_COUNTER_CORE_ASSERT_SVH
`define PALINDROMIC_SUBSTRING_COUNTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/psc_pkg.sv
`timescale 1ns / 1ps
package psc_pkg;

  localparam int SYM_W       = 8;
  localparam int COUNT_W     = 20;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam int PSC_MAX_LEN = 1024;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  // What one cell hands to its downstream neighbors.
  typedef struct packed {
    logic [SYM_W-1:0] sym;  // symbol held (history tap)
    logic             hv;   // tap holds a real symbol of this string
    logic             pal;  // palindrome of this cell's length ended last symbol
  } psc_link_t;

  // Per-word sideband traveling alongside the popcount tree.
  typedef struct packed {
    logic valid;
    logic last;
    logic ovf;
  } psc_tok_t;

endpackage

// File: hw/rtl/psc_cell.sv
`timescale 1ns / 1ps
// One length slot: history tap i and the "palindrome of length i+1" bit.
module psc_cell import psc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             restart,
  input  logic [SYM_W-1:0] symbol,
  input  psc_link_t        prev,   // from cell i-1
  input  psc_link_t        prev2,  // from cell i-2 (pal only)
  output psc_link_t        link,
  output logic             pal_q
);

  logic [SYM_W-1:0] hist;
  logic             hv;
  logic             pal_next;

  // length L+2 palindrome: length L ended before and outer symbols match
  assign pal_next = prev2.pal && prev.hv && (prev.sym == symbol);

  always_ff @(posedge clk) begin
    if (rst) begin
      hv    <= 1'b0;
      pal_q <= 1'b0;
    end else if (en) begin
      hv    <= prev.hv;
      pal_q <= pal_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hist <= prev.sym;
    end
  end

  // after a final symbol the old string reads as cleared
  assign link.sym = hist;
  assign link.hv  = hv && !restart;
  assign link.pal = pal_q && !restart;

endmodule

// File: hw/rtl/psc_popcount.sv
`timescale 1ns / 1ps
// Registered binary adder tree, one register per level.
module psc_popcount import psc_pkg::*; #(
  parameter  int N  = PSC_MAX_LEN,
  localparam int W  = $clog2(N + 1),
  localparam int LV = $clog2(N),
  localparam int P  = 1 << LV
) (
  input  logic         clk,
  input  logic         en,
  input  logic [N-1:0] bits,
  output logic [W-1:0] sum
);

  logic [P-1:0] padded;
  logic [W-1:0] node [1:P-1];
  logic [W-1:0] val  [1:2*P-1];

  assign padded = P'(bits);

  always_comb begin
    for (int j = P; j < 2 * P; j++) begin
      val[j] = W'(padded[j-P]);
    end
    for (int k = 1; k < P; k++) begin
      val[k] = node[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k < P; k++) begin
        node[k] <= val[2*k] + val[2*k+1];
      end
    end
  end

  assign sum = node[1];

endmodule

// File: hw/rtl/palindromic_substring_counter_core.sv
// Path from symbol accept to result word: cell row register, adder tree, output register.
// Throughput: one word per cycle while the output is taken; the cell row is registered, the hit
//   popcount runs through a registered adder tree of clog2(MAX_LEN) levels.
// Whole pipeline stalls together while the output word is not taken.
// Reset: rst synchronous, active high; clears cell flags, count and valids.
`timescale 1ns / 1ps
`include "palindromic_substring_counter_core_assert.svh"
module palindromic_substring_counter_core import psc_pkg::*; #(
  parameter int MAX_LEN = PSC_MAX_LEN
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] symbol
  input  logic                   s_axis_tlast,   // last symbol of string
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [19:0] pal_count, [23:20] zero
  output logic                   m_axis_tuser,   // [0] overflow
  output logic                   m_axis_tlast    // is_last
);

  localparam int LV    = $clog2(MAX_LEN);
  localparam int HIT_W = $clog2(MAX_LEN + 1);

  logic               advance;
  logic               accept;
  logic               restart;   // previous word closed a string
  psc_link_t          chain [0:MAX_LEN+1];
  logic [MAX_LEN-1:0] pal_bits;
  logic [HIT_W-1:0]   hits;
  psc_tok_t           tok [0:LV];
  logic [COUNT_W-1:0] count;
  logic [COUNT_W:0]   sum_ext;
  logic [COUNT_W-1:0] count_sum;

  // Pipeline moves whenever the output register is free or being drained.
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Two head links: a length-0 "palindrome" always ends, and the new
  // symbol sits in front of the history.
  assign chain[0] = '{sym: s_axis_tdata[SYM_W-1:0], hv: 1'b1, pal: 1'b1};
  assign chain[1] = '{sym: s_axis_tdata[SYM_W-1:0], hv: 1'b1, pal: 1'b1};

  // Cell row: cell i handles length i+1 and history tap i.
  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    psc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (accept),
      .restart (restart),
      .symbol  (s_axis_tdata[SYM_W-1:0]),
      .prev    (chain[i+1]),
      .prev2   (chain[i]),
      .link    (chain[i+2]),
      .pal_q   (pal_bits[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      restart <= 1'b0;
    end else if (accept) begin
      restart <= s_axis_tlast;
    end
  end

  // Hits for a word = number of set length bits right after its update.
  psc_popcount #(.N(MAX_LEN)) u_popcount (
    .clk  (clk),
    .en   (advance),
    .bits (pal_bits),
    .sum  (hits)
  );

  // Sideband rides alongside the tree. Overflow: last tap already held a
  // symbol of this string, so the string is now past MAX_LEN.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= LV; j++) begin
        tok[j] <= '0;
      end
    end else if (advance) begin
      tok[0] <= '{valid: accept, last: s_axis_tlast, ovf: chain[MAX_LEN+1].hv};
      for (int j = 1; j <= LV; j++) begin
        tok[j] <= tok[j-1];
      end
    end
  end

  // Saturating running count.
  assign sum_ext   = {1'b0, count} + (COUNT_W + 1)'(hits);
  assign count_sum = sum_ext[COUNT_W] ? COUNT_MAX : sum_ext[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      count         <= '0;
    end else if (advance) begin
      m_axis_tvalid <= tok[LV].valid;
      if (tok[LV].valid) begin
        count <= tok[LV].last ? '0 : count_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tok[LV].valid) begin
      m_axis_tdata <= OUT_TDATA_W'(count_sum);
      m_axis_tuser <= tok[LV].ovf;
      m_axis_tlast <= tok[LV].last;
    end
  end

  // Length-1 palindrome always ends at the newest symbol.
  `PSC_ASSERT_NXT(a_len1_set, accept, pal_bits[0], "length-1 bit not set after accept")

  // Within a string the count never goes backwards.
  `PSC_ASSERT_NXT(a_count_mono,
                  advance && tok[LV].valid && !tok[LV].last,
                  count >= $past(count),
                  "running count decreased")

  // An overflowing string has more than MAX_LEN symbols, each adding at least one.
  `PSC_ASSERT_IMP(a_ovf_count,
                  m_axis_tvalid && m_axis_tuser,
                  m_axis_tdata[COUNT_W-1:0] > COUNT_W'(MAX_LEN),
                  "overflow with too small a count")

endmodule
